### hw/rtl/dcrcv_pkg.sv
`default_nettype none

package dcrcv_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_CRC_POLY     = 2'd0;
    localparam logic [1:0] REG_CRC_INIT     = 2'd1;
    localparam logic [1:0] REG_DEFAULT_FILL = 2'd2;

    localparam logic [15:0] CRC_POLY_RESET     = 16'h1021;
    localparam logic [15:0] CRC_INIT_RESET     = 16'hFFFF;
    localparam logic [7:0]  DEFAULT_FILL_RESET = 8'h00;

    // Codes of the source field.
    localparam logic [1:0] SRC_A    = 2'd0;
    localparam logic [1:0] SRC_B    = 2'd1;
    localparam logic [1:0] SRC_FILL = 2'd2;

    // Payload buffer banks, and records that may be buffered at once.
    localparam int NUM_BANKS = 2;

    typedef struct packed {
        logic [7:0] copy_a_byte;
        logic [7:0] copy_b_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] source;
        logic       copy_a_good;
        logic       copy_b_good;
        logic       last_of_run;
    } out_item_t;

    // Verdict on one record, handed from the front end to the emitter.
    typedef struct packed {
        logic       bank;
        logic [1:0] source;
        logic       copy_a_good;
        logic       copy_b_good;
    } rec_desc_t;

    typedef struct packed {
        logic record_done;
    } back_status_t;

    // One byte of an MSB-first CRC-16, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dcrcv_ram.sv
`default_nettype none

module dcrcv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/dcrcv_front.sv
`default_nettype none

module dcrcv_front #(
    parameter int RECORD_BYTES = 24,
    localparam int PAYLOAD_LEN = RECORD_BYTES - 2,
    localparam int PIDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1,
    localparam int ADDR_W = PIDX_W + 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire dcrcv_pkg::in_item_t       item_data,
    input  wire logic [15:0]               crc_poly,
    input  wire logic [15:0]               crc_init,
    output logic                           ram_we,
    output logic [ADDR_W-1:0]              ram_waddr,
    output logic [15:0]                    ram_wdata,
    output logic                           push,
    output dcrcv_pkg::rec_desc_t           desc,
    input  wire dcrcv_pkg::back_status_t   bstat
);

    import dcrcv_pkg::*;

    localparam int OFF_W = $clog2(RECORD_BYTES);

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [15:0]      crc_a_reg, crc_a_next;
    logic [15:0]      crc_b_reg, crc_b_next;
    logic [7:0]       lo_a_reg, lo_a_next;
    logic [7:0]       lo_b_reg, lo_b_next;
    logic             bank_reg, bank_next;
    logic [1:0]       in_flight_reg, in_flight_next;

    logic             accept;
    logic             is_payload;
    logic             is_lo;
    logic [15:0]      crc_a_base;
    logic [15:0]      crc_b_base;
    logic             good_a;
    logic             good_b;

    assign item_stall = (offset_reg == '0) && (in_flight_reg == 2'(NUM_BANKS));
    assign accept     = item_valid && !item_stall;
    assign is_payload = offset_reg < OFF_W'(PAYLOAD_LEN);
    assign is_lo      = offset_reg == OFF_W'(PAYLOAD_LEN);
    assign crc_a_base = (offset_reg == '0) ? crc_init : crc_a_reg;
    assign crc_b_base = (offset_reg == '0) ? crc_init : crc_b_reg;

    // On the final byte the incoming bytes are the high halves of the stored CRCs.
    assign good_a = crc_a_reg == {item_data.copy_a_byte, lo_a_reg};
    assign good_b = crc_b_reg == {item_data.copy_b_byte, lo_b_reg};

    assign ram_we    = accept && is_payload;
    assign ram_waddr = {bank_reg, offset_reg[PIDX_W-1:0]};
    assign ram_wdata = {item_data.copy_a_byte, item_data.copy_b_byte};

    assign push             = accept && !is_payload && !is_lo;
    assign desc.bank        = bank_reg;
    assign desc.copy_a_good = good_a;
    assign desc.copy_b_good = good_b;
    assign desc.source      = good_a ? SRC_A : (good_b ? SRC_B : SRC_FILL);

    always_comb
    begin
        offset_next = offset_reg;
        crc_a_next  = crc_a_reg;
        crc_b_next  = crc_b_reg;
        lo_a_next   = lo_a_reg;
        lo_b_next   = lo_b_reg;
        bank_next   = bank_reg;
        if (accept)
        begin
            if (is_payload)
            begin
                crc_a_next  = crc_byte(crc_a_base, item_data.copy_a_byte, crc_poly);
                crc_b_next  = crc_byte(crc_b_base, item_data.copy_b_byte, crc_poly);
                offset_next = offset_reg + OFF_W'(1);
            end
            else if (is_lo)
            begin
                lo_a_next   = item_data.copy_a_byte;
                lo_b_next   = item_data.copy_b_byte;
                offset_next = offset_reg + OFF_W'(1);
            end
            else
            begin
                offset_next = '0;
                bank_next   = !bank_reg;
            end
        end
        in_flight_next = in_flight_reg + 2'(push) - 2'(bstat.record_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            bank_reg      <= 1'b0;
            in_flight_reg <= '0;
            crc_a_reg     <= CRC_INIT_RESET;
            crc_b_reg     <= CRC_INIT_RESET;
            lo_a_reg      <= '0;
            lo_b_reg      <= '0;
        end
        else
        begin
            offset_reg    <= offset_next;
            bank_reg      <= bank_next;
            in_flight_reg <= in_flight_next;
            crc_a_reg     <= crc_a_next;
            crc_b_reg     <= crc_b_next;
            lo_a_reg      <= lo_a_next;
            lo_b_reg      <= lo_b_next;
        end
    end

    // More records in flight than banks would mean a bank is overwritten while read.
    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= 2'(NUM_BANKS))
        else $error("records in flight exceed buffer banks");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> in_flight_reg != '0)
        else $error("pushed record not counted in flight");

    a_record_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (offset_reg == '0) && (bank_reg != $past(bank_reg)))
        else $error("record end did not restart offset and swap bank");

endmodule

`default_nettype wire

### hw/rtl/dcrcv_queue.sv
`default_nettype none

module dcrcv_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire dcrcv_pkg::rec_desc_t  push_desc,
    input  wire logic                  pop,
    output logic                       empty,
    output dcrcv_pkg::rec_desc_t       head
);

    import dcrcv_pkg::*;

    rec_desc_t  entry_reg [NUM_BANKS];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'(NUM_BANKS)) || pop)
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("record queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(NUM_BANKS))
        else $error("record queue count out of range");

endmodule

`default_nettype wire

### hw/rtl/dcrcv_back.sv
`default_nettype none

module dcrcv_back #(
    parameter int RECORD_BYTES = 24,
    localparam int PAYLOAD_LEN = RECORD_BYTES - 2,
    localparam int PIDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1,
    localparam int ADDR_W = PIDX_W + 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire dcrcv_pkg::rec_desc_t   q_head,
    output logic                        pop,
    output logic                        ram_re,
    output logic [ADDR_W-1:0]           ram_raddr,
    input  wire logic [15:0]            ram_rdata,
    input  wire logic [7:0]             default_fill,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output dcrcv_pkg::out_item_t        result_data,
    output dcrcv_pkg::back_status_t     bstat
);

    import dcrcv_pkg::*;

    logic              run_reg, run_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    rec_desc_t         desc_reg, desc_next;

    // Read stage: RAM data register plus its sideband.
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg, s1_last_next;
    rec_desc_t         s1_desc_reg, s1_desc_next;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              advance;
    logic              issue;
    logic              at_last;
    logic [7:0]        sel_byte;

    assign advance   = !out_valid_reg || !result_stall;
    assign issue     = advance && run_reg;
    assign at_last   = idx_reg == PIDX_W'(PAYLOAD_LEN - 1);
    assign pop       = !run_reg && !q_empty;
    assign ram_re    = issue;
    assign ram_raddr = {desc_reg.bank, idx_reg};

    always_comb
    begin
        case (s1_desc_reg.source)
            SRC_A:   sel_byte = ram_rdata[15:8];
            SRC_B:   sel_byte = ram_rdata[7:0];
            default: sel_byte = default_fill;
        endcase
    end

    always_comb
    begin
        run_next       = run_reg;
        idx_next       = idx_reg;
        desc_next      = desc_reg;
        s1_valid_next  = s1_valid_reg;
        s1_last_next   = s1_last_reg;
        s1_desc_next   = s1_desc_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (pop)
        begin
            run_next  = 1'b1;
            idx_next  = '0;
            desc_next = q_head;
        end
        else if (issue)
        begin
            idx_next = idx_reg + PIDX_W'(1);
            if (at_last)
                run_next = 1'b0;
        end

        if (advance)
        begin
            s1_valid_next             = issue;
            s1_last_next              = at_last;
            s1_desc_next              = desc_reg;
            out_valid_next            = s1_valid_reg;
            out_item_next.data_byte   = sel_byte;
            out_item_next.source      = s1_desc_reg.source;
            out_item_next.copy_a_good = s1_desc_reg.copy_a_good;
            out_item_next.copy_b_good = s1_desc_reg.copy_b_good;
            out_item_next.last_of_run = s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        desc_reg     <= desc_next;
        s1_last_reg  <= s1_last_next;
        s1_desc_reg  <= s1_desc_next;
        out_item_reg <= out_item_next;
    end

    assign result_valid      = out_valid_reg;
    assign result_data       = out_item_reg;
    assign bstat.record_done = out_valid_reg && !result_stall && out_item_reg.last_of_run;

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> run_reg && (idx_reg == '0))
        else $error("record load did not start a run");

    a_fill_means_both_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.source == SRC_FILL))
            |-> !result_data.copy_a_good && !result_data.copy_b_good)
        else $error("fill emitted although a copy is good");

    a_b_only_when_a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.source == SRC_B))
            |-> !result_data.copy_a_good && result_data.copy_b_good)
        else $error("copy B chosen with wrong verdicts");

endmodule

`default_nettype wire

### hw/rtl/dual_copy_record_crc_validator.sv
`default_nettype none

// Channel   Handshake                   Payload                 Moves
// item      item_valid / item_stall     item_data (in_item_t)   one byte pair per item
// result    result_valid / result_stall result_data (out_item_t) one payload byte per item
// config    cfg_we                      cfg_index, cfg_data     one register write
//
// The front end takes one byte pair per cycle unless intake stalls. A record of
// RECORD_BYTES items ends in one verdict; then PAYLOAD_LEN result items leave one per
// cycle unless the result side stalls, from a registered RAM read, once the verdict has
// passed the queue. Two payload banks let the next record stream in during the emit;
// intake stalls only at the start of a record while both banks still hold unsent records.
// Reset is asynchronous and active low; no clearing pass is needed after it.

module dual_copy_record_crc_validator #(
    parameter int RECORD_BYTES = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire dcrcv_pkg::in_item_t  item_data,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output dcrcv_pkg::out_item_t      result_data,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);

    import dcrcv_pkg::*;

    localparam int PAYLOAD_LEN = RECORD_BYTES - 2;
    localparam int PIDX_W      = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam int ADDR_W      = PIDX_W + 1;
    localparam int RAM_DEPTH   = NUM_BANKS * (2 ** PIDX_W);

    // Configuration registers. Writes are to land only while the block is idle; the user
    // must ensure it, the block does not enforce it. The front end and emitter read them directly.
    logic [15:0] crc_poly_reg, crc_poly_next;
    logic [15:0] crc_init_reg, crc_init_next;
    logic [7:0]  fill_reg, fill_next;

    always_comb
    begin
        crc_poly_next = crc_poly_reg;
        crc_init_next = crc_init_reg;
        fill_next     = fill_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CRC_POLY:     crc_poly_next = cfg_data;
                REG_CRC_INIT:     crc_init_next = cfg_data;
                REG_DEFAULT_FILL: fill_next     = cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg <= CRC_POLY_RESET;
            crc_init_reg <= CRC_INIT_RESET;
            fill_reg     <= DEFAULT_FILL_RESET;
        end
        else
        begin
            crc_poly_reg <= crc_poly_next;
            crc_init_reg <= crc_init_next;
            fill_reg     <= fill_next;
        end
    end

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    logic              push;
    rec_desc_t         push_desc;
    logic              pop;
    logic              q_empty;
    rec_desc_t         q_head;
    back_status_t      bstat;

    // The front end runs both CRCs, stores the payload pair and judges the record.
    dcrcv_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .crc_poly   (crc_poly_reg),
        .crc_init   (crc_init_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .push       (push),
        .desc       (push_desc),
        .bstat      (bstat)
    );

    // Verdicts wait here until the emitter is free.
    dcrcv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Copy A byte in the upper half of each word, copy B in the lower half.
    dcrcv_ram #(.WIDTH(16), .DEPTH(RAM_DEPTH)) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The emitter walks the chosen bank and sends one result item per cycle while not stalled.
    dcrcv_back #(.RECORD_BYTES(RECORD_BYTES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .default_fill (fill_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .bstat        (bstat)
    );

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import dcrcv_pkg::*;

    // One record is RECORD_BYTES byte pairs: a payload of PAYLOAD_LEN bytes
    // followed by the stored CRC of each copy, low byte first.
    localparam int RECORD_BYTES = 24;
    localparam int PAYLOAD_LEN  = RECORD_BYTES - 2;

    // Cycles left after the last expected result before the block counts as idle.
    localparam int SETTLE_CYCLES = 10;
    // Length of the deliberate hold-off on the result side.
    localparam int HOLD_CYCLES   = 300;
    // Cycles with no item moving on either channel before the run is abandoned.
    localparam int QUIET_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;

    // Shapes of the records that the stimulus builds. Every well-formed record
    // carries correct CRCs that are then spoiled on the copies that must fail.
    typedef enum {
        REC_BOTH_GOOD,
        REC_A_ONLY,
        REC_B_ONLY,
        REC_NEITHER,
        REC_NOISE,
        REC_EXTREMES
    } rec_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    in_item_t    item_data = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_item_t   result_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_CRC_POLY;
    logic [15:0] cfg_data = '0;

    dual_copy_record_crc_validator #(
        .RECORD_BYTES (RECORD_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Byte pairs waiting to be offered, and payload bytes the block still owes.
    in_item_t  pending_pairs[$];
    out_item_t expected_bytes[$];

    // Register copies as the block should hold them.
    logic [15:0] cfg_poly = CRC_POLY_RESET;
    logic [15:0] cfg_init = CRC_INIT_RESET;
    logic [7:0]  cfg_fill = DEFAULT_FILL_RESET;

    // Record state of the prediction: running CRCs, buffered payloads, the
    // stored CRCs as they arrive and the position inside the current record.
    logic [15:0] run_crc_a;
    logic [15:0] run_crc_b;
    logic [7:0]  buf_a [PAYLOAD_LEN];
    logic [7:0]  buf_b [PAYLOAD_LEN];
    logic [15:0] held_crc_a = '0;
    logic [15:0] held_crc_b = '0;
    int          rec_offset = 0;

    int   fault_count = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   holds_asked = 0;
    int   holds_done = 0;
    int   hold_left = 0;
    logic pair_taken = 1'b0;

    // One byte of an MSB-first CRC-16 under the current polynomial. The data
    // bits are fed in one at a time against the register's top bit.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            if (acc[15] ^ b[i])
                acc = (acc << 1) ^ cfg_poly;
            else
                acc = acc << 1;
        end
        return acc;
    endfunction

    // Advance the prediction by one accepted byte pair. Only the last pair of
    // a record yields results: the whole chosen payload, one byte per item.
    function automatic void take_pair(input in_item_t p);
        logic      ok_a;
        logic      ok_b;
        logic [1:0] src;
        out_item_t r;
        if (rec_offset < PAYLOAD_LEN)
        begin
            // The CRCs restart from the init register at the first byte of a record.
            run_crc_a = crc16_step((rec_offset == 0) ? cfg_init : run_crc_a, p.copy_a_byte);
            run_crc_b = crc16_step((rec_offset == 0) ? cfg_init : run_crc_b, p.copy_b_byte);
            buf_a[rec_offset] = p.copy_a_byte;
            buf_b[rec_offset] = p.copy_b_byte;
            rec_offset++;
        end
        else if (rec_offset == PAYLOAD_LEN)
        begin
            held_crc_a[7:0] = p.copy_a_byte;
            held_crc_b[7:0] = p.copy_b_byte;
            rec_offset++;
        end
        else
        begin
            held_crc_a[15:8] = p.copy_a_byte;
            held_crc_b[15:8] = p.copy_b_byte;
            rec_offset = 0;
            ok_a = (run_crc_a == held_crc_a);
            ok_b = (run_crc_b == held_crc_b);
            // Copy A wins whenever it is good, even if copy B is good too.
            src = ok_a ? SRC_A : (ok_b ? SRC_B : SRC_FILL);
            for (int k = 0; k < PAYLOAD_LEN; k++)
            begin
                if (src == SRC_A)
                    r.data_byte = buf_a[k];
                else if (src == SRC_B)
                    r.data_byte = buf_b[k];
                else
                    r.data_byte = cfg_fill;
                r.source      = src;
                r.copy_a_good = ok_a;
                r.copy_b_good = ok_b;
                r.last_of_run = (k == PAYLOAD_LEN - 1);
                expected_bytes.push_back(r);
            end
        end
    endfunction

    // Compare one accepted result item against the oldest payload byte owed.
    function automatic void check_result(input out_item_t got);
        out_item_t want;
        if (expected_bytes.size() == 0)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("%0t: result item with nothing owed: data %02h source %0d",
                         $realtime, got.data_byte, got.source);
            return;
        end
        want = expected_bytes.pop_front();
        if (got.data_byte !== want.data_byte || got.source !== want.source ||
            got.copy_a_good !== want.copy_a_good || got.copy_b_good !== want.copy_b_good ||
            got.last_of_run !== want.last_of_run)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
            begin
                $display("%0t: result mismatch: expected data %02h src %0d a %0b b %0b last %0b",
                         $realtime, want.data_byte, want.source, want.copy_a_good,
                         want.copy_b_good, want.last_of_run);
                $display("%0t:                  got      data %02h src %0d a %0b b %0b last %0b",
                         $realtime, got.data_byte, got.source, got.copy_a_good,
                         got.copy_b_good, got.last_of_run);
            end
        end
    endfunction

    // Build one record of the given shape and queue its byte pairs. The CRCs
    // use the register values in force, which cannot change while it streams.
    function automatic void queue_record(input rec_kind_t kind);
        logic [7:0]  a_bytes [RECORD_BYTES];
        logic [7:0]  b_bytes [RECORD_BYTES];
        logic [15:0] crc_a;
        logic [15:0] crc_b;
        in_item_t    pair;
        crc_a = cfg_init;
        crc_b = cfg_init;
        for (int k = 0; k < RECORD_BYTES; k++)
        begin
            if (kind == REC_EXTREMES)
            begin
                a_bytes[k] = k[0] ? 8'hFF : 8'h00;
                b_bytes[k] = ~a_bytes[k];
            end
            else
            begin
                a_bytes[k] = 8'($urandom_range(255));
                // Now and then a byte is the same on both copies.
                b_bytes[k] = ($urandom_range(3) == 0) ? a_bytes[k] : 8'($urandom_range(255));
            end
        end
        if (kind != REC_NOISE)
        begin
            for (int k = 0; k < PAYLOAD_LEN; k++)
            begin
                crc_a = crc16_step(crc_a, a_bytes[k]);
                crc_b = crc16_step(crc_b, b_bytes[k]);
            end
            a_bytes[PAYLOAD_LEN]     = crc_a[7:0];
            a_bytes[PAYLOAD_LEN + 1] = crc_a[15:8];
            b_bytes[PAYLOAD_LEN]     = crc_b[7:0];
            b_bytes[PAYLOAD_LEN + 1] = crc_b[15:8];
            // A single flipped bit in a stored CRC always breaks that copy.
            if (kind == REC_B_ONLY || kind == REC_NEITHER)
                a_bytes[PAYLOAD_LEN + $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
            if (kind == REC_A_ONLY || kind == REC_NEITHER)
                b_bytes[PAYLOAD_LEN + $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
        end
        for (int k = 0; k < RECORD_BYTES; k++)
        begin
            pair.copy_a_byte = a_bytes[k];
            pair.copy_b_byte = b_bytes[k];
            pending_pairs.push_back(pair);
        end
    endfunction

    // Mostly well-formed records with a fair share of each verdict, and a
    // few records of pure noise.
    function automatic rec_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return REC_BOTH_GOOD;
        else if (r < 50)
            return REC_A_ONLY;
        else if (r < 75)
            return REC_B_ONLY;
        else if (r < 90)
            return REC_NEITHER;
        return REC_NOISE;
    endfunction

    // Sample both channels at the rising edge. The prediction runs before the
    // check so that the order of the two can never matter.
    always @(posedge clk)
    begin
        pair_taken = rst_n && item_valid && !item_stall;
        if (pair_taken)
            take_pair(item_data);
        if (rst_n && result_valid && !result_stall)
            check_result(result_data);
        if (rst_n && !pair_taken && !(result_valid && !result_stall))
            quiet_cycles++;
        else
            quiet_cycles = 0;
    end

    // Sender: offers the next queued byte pair once the previous one has been
    // taken, with random gaps. A pair that is not taken stays on the bus.
    always @(negedge clk)
    begin
        if (!item_valid || pair_taken)
        begin
            if (rst_n && pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item_data  <= pending_pairs.pop_front();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, and on request holds off for a long stretch
    // so that both payload banks fill and the block stalls its intake.
    always @(negedge clk)
    begin
        if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // Register writes go out only while the block is idle, and the copies
    // used for prediction follow at the same edge.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_CRC_POLY:     cfg_poly = val;
            REG_CRC_INIT:     cfg_init = val;
            REG_DEFAULT_FILL: cfg_fill = val[7:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] poly, input logic [15:0] init,
                             input logic [7:0] fill);
        write_reg(REG_CRC_POLY, poly);
        write_reg(REG_CRC_INIT, init);
        write_reg(REG_DEFAULT_FILL, {8'h00, fill});
    endtask

    // Queue random records, then wait until every pair has been sent, every owed byte
    // has arrived and the emitter has had time to go quiet.
    task automatic run_records(input int count);
        for (int n = 0; n < count; n++)
            queue_record(pick_kind());
        while (pending_pairs.size() != 0 || item_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values; the sender rarely idles, the receiver often does.
        send_idle_pct = 8;
        recv_idle_pct = 84;
        // All-zero and all-one bytes on both copies with good CRCs: copy A must win.
        queue_record(REC_EXTREMES);
        run_records(2);

        // Extreme register values: every polynomial bit set, zero init, fill of ones.
        write_all(16'hFFFF, 16'h0000, 8'hFF);
        run_records(2);

        // Roles swapped: the sender idles most of the time.
        send_idle_pct = 84;
        recv_idle_pct = 8;
        // A zero polynomial reduces the CRC to a plain shift register.
        write_all(16'h0000, 16'hFFFF, 8'h00);
        run_records(1);

        write_all(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  8'($urandom_range(255)));
        run_records(2);

        // No idling; the long receiver hold-off starts as the records go in,
        // so the sender keeps offering while both banks are full.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'h8005, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
        holds_asked++;
        run_records(4);

        if (fault_count == 0 && expected_bytes.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### dual_copy_record_crc_validator.f
hw/rtl/dcrcv_pkg.sv
hw/rtl/dcrcv_ram.sv
hw/rtl/dcrcv_front.sv
hw/rtl/dcrcv_queue.sv
hw/rtl/dcrcv_back.sv
hw/rtl/dual_copy_record_crc_validator.sv
test/tb_top.sv
